// ----- hw/rtl/lpcp_pkg.sv -----
// lidar point camera projection: shared register map, config struct, reset values
// depends on nothing; every other file uses it
package lpcp_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;
  localparam int TRANS_W    = 16;
  localparam int FOCAL_W    = 16;
  localparam int CENTER_W   = 16;

  // register indexes of the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAM_X    = 4'd0,
    REG_CAM_Y    = 4'd1,
    REG_CAM_Z    = 4'd2,
    REG_TRANS    = 4'd3,
    REG_FOCAL_U  = 4'd4,
    REG_CENTER_U = 4'd5,
    REG_FOCAL_V  = 4'd6,
    REG_CENTER_V = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0]      coef_x;
    logic [CFG_DATA_W-1:0]      coef_y;
    logic [CFG_DATA_W-1:0]      coef_z;
    logic [CFG_DATA_W-1:0]      trans;
    logic [FOCAL_W-1:0]         focal_u;
    logic signed [CENTER_W-1:0] center_u;
    logic [FOCAL_W-1:0]         focal_v;
    logic signed [CENTER_W-1:0] center_v;
  } cfg_t;

  localparam logic [FOCAL_W-1:0]  FOCAL_U_RST  = 16'd9110;
  localparam logic [CENTER_W-1:0] CENTER_U_RST = 16'd15778;
  localparam logic [FOCAL_W-1:0]  FOCAL_V_RST  = 16'd10482;
  localparam logic [CENTER_W-1:0] CENTER_V_RST = 16'd4129;

endpackage

// ----- hw/rtl/lpcp_if.sv -----
// stream and config channel interfaces of the projection unit
// depends on lpcp_pkg for config port widths
interface lpcp_in_if #(parameter int CW = 18);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface lpcp_out_if #(parameter int PW = 16, parameter int DW = 20);
  logic                 valid;
  logic                 ready;
  logic signed [PW-1:0] pixel_u;
  logic signed [PW-1:0] pixel_v;
  logic signed [DW-1:0] depth;
  logic                 saturated;
  modport source (output valid, pixel_u, pixel_v, depth, saturated, input ready);
  modport sink   (input valid, pixel_u, pixel_v, depth, saturated, output ready);
endinterface

interface lpcp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lpcp_pkg::CFG_IDX_W-1:0]  index;
  logic [lpcp_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/lidar_point_camera_projection_unit.sv -----
// top level of the lidar point to camera pixel projection unit
// depends on lpcp_pkg, lpcp_if, lpcp_cfg_regs, lpcp_transform, lpcp_project
//
//   channel  | dir | beat
//   in_pt    | in  | point_x, point_y, point_z (1/256 m)
//   out_px   | out | pixel_u, pixel_v (1/16 px), depth (1/256 m), saturated
//   cfg_wr   | in  | index, data: one register write, always ready
//
// one point per cycle while the output beat is not held; the pipe is 2 transform stages
// + 3 divide prep stages + (max(PIXEL_WIDTH,16)+1) quotient-bit stages + 1 output stage;
// the quotient-bit chain sets the depth
// rst_n clears all valid bits and loads register reset values
// when the output beat is held, the whole pipe freezes and in_pt.ready drops
module lidar_point_camera_projection_unit
  import lpcp_pkg::*;
#(
  parameter int COORD_WIDTH = 18,
  parameter int COEF_WIDTH  = 16,
  parameter int PIXEL_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  lpcp_in_if.sink     in_pt,
  lpcp_out_if.source  out_px,
  lpcp_cfg_if.sink    cfg_wr
);

  localparam int BW  = (COORD_WIDTH > TRANS_W) ? COORD_WIDTH : TRANS_W;
  localparam int CCW = BW + 4;

  cfg_t                  cfg;
  logic                  en;
  logic                  tv;
  logic signed [CCW-1:0] cam [3];

  // global advance: move unless a held output beat blocks
  assign en          = !out_px.valid || out_px.ready;
  assign in_pt.ready = en;

  lpcp_cfg_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_wr),
    .cfg_o (cfg)
  );

  lpcp_transform #(
    .CW  (COORD_WIDTH),
    .KW  (COEF_WIDTH),
    .CCW (CCW)
  ) u_xform (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cfg_i   (cfg),
    .valid_i (in_pt.valid),
    .px      (in_pt.point_x),
    .py      (in_pt.point_y),
    .pz      (in_pt.point_z),
    .valid_o (tv),
    .cam_o   (cam)
  );

  lpcp_project #(
    .CW  (COORD_WIDTH),
    .CCW (CCW),
    .PW  (PIXEL_WIDTH)
  ) u_proj (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cfg_i   (cfg),
    .valid_i (tv),
    .cam_i   (cam),
    .valid_o (out_px.valid),
    .pix_u   (out_px.pixel_u),
    .pix_v   (out_px.pixel_v),
    .depth_o (out_px.depth),
    .sat_o   (out_px.saturated)
  );

  // checks
  localparam logic signed [PIXEL_WIDTH-1:0] PIX_MAX = {1'b0, {(PIXEL_WIDTH-1){1'b1}}};
  localparam logic signed [PIXEL_WIDTH-1:0] PIX_MIN = {1'b1, {(PIXEL_WIDTH-1){1'b0}}};

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_px.valid)
    else $error("output valid after reset");

  a_zero_depth_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_px.valid && out_px.depth == '0 |-> out_px.saturated)
    else $error("zero depth without saturation flag");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_px.valid && out_px.saturated |->
      out_px.pixel_u == PIX_MAX || out_px.pixel_u == PIX_MIN ||
      out_px.pixel_v == PIX_MAX || out_px.pixel_v == PIX_MIN)
    else $error("saturation flag without clipped pixel");

endmodule

// ----- hw/rtl/lpcp_cfg_regs.sv -----
// configuration register file of the projection unit
// depends on lpcp_pkg and lpcp_cfg_if
module lpcp_cfg_regs
  import lpcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  lpcp_cfg_if.sink   cfg,
  output cfg_t       cfg_o
);

  cfg_t regs_r;

  assign cfg.ready = 1'b1;
  assign cfg_o     = regs_r;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.coef_x   <= '0;
      regs_r.coef_y   <= '0;
      regs_r.coef_z   <= '0;
      regs_r.trans    <= '0;
      regs_r.focal_u  <= FOCAL_U_RST;
      regs_r.center_u <= CENTER_U_RST;
      regs_r.focal_v  <= FOCAL_V_RST;
      regs_r.center_v <= CENTER_V_RST;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_CAM_X:    regs_r.coef_x   <= cfg.data;
        REG_CAM_Y:    regs_r.coef_y   <= cfg.data;
        REG_CAM_Z:    regs_r.coef_z   <= cfg.data;
        REG_TRANS:    regs_r.trans    <= cfg.data;
        REG_FOCAL_U:  regs_r.focal_u  <= cfg.data[FOCAL_W-1:0];
        REG_CENTER_U: regs_r.center_u <= cfg.data[CENTER_W-1:0];
        REG_FOCAL_V:  regs_r.focal_v  <= cfg.data[FOCAL_W-1:0];
        REG_CENTER_V: regs_r.center_v <= cfg.data[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/lpcp_transform.sv -----
// rigid transform: 3x3 coefficient products, then sum, translation and rounding
// depends on lpcp_pkg; two register stages
module lpcp_transform
  import lpcp_pkg::*;
#(
  parameter int CW  = 18,
  parameter int KW  = 16,
  parameter int CCW = 22
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  cfg_t                  cfg_i,
  input  logic                  valid_i,
  input  logic signed [CW-1:0]  px,
  input  logic signed [CW-1:0]  py,
  input  logic signed [CW-1:0]  pz,
  output logic                  valid_o,
  output logic signed [CCW-1:0] cam_o [3]
);

  localparam int F  = KW - 2;
  localparam int PRW = CW + KW;
  localparam int AW = CCW + F;

  logic [3*KW-1:0]        coef [3];
  logic signed [CW-1:0]   pt [3];
  logic signed [PRW-1:0]  prod_r [3][3];
  logic                   va_r, vb_r;
  logic signed [CCW-1:0]  cam_r [3];
  logic signed [AW-1:0]   acc [3];

  assign coef[0] = (3*KW)'(cfg_i.coef_x);
  assign coef[1] = (3*KW)'(cfg_i.coef_y);
  assign coef[2] = (3*KW)'(cfg_i.coef_z);
  assign pt[0] = px;
  assign pt[1] = py;
  assign pt[2] = pz;

  // stage a: nine products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 3; i++) begin
          prod_r[a][i] <= PRW'(pt[i] * $signed(coef[a][i*KW +: KW]));
        end
      end
    end
  end

  // stage b: sum, translation, round half up
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      acc[a] = AW'(prod_r[a][0]) + AW'(prod_r[a][1]) + AW'(prod_r[a][2])
             + (AW'($signed(cfg_i.trans[a*TRANS_W +: TRANS_W])) <<< F)
             + (AW'(1) <<< (F - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        cam_r[a] <= CCW'(acc[a] >>> F);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= valid_i;
      vb_r <= va_r;
    end
  end

  assign valid_o = vb_r;
  assign cam_o   = cam_r;

endmodule

// ----- hw/rtl/lpcp_project.sv -----
// perspective divide for u and v lanes: focal product, sign split, overflow test,
// one quotient bit per stage, then center offset and clipping; depends on lpcp_pkg
module lpcp_project
  import lpcp_pkg::*;
#(
  parameter int CW  = 18,
  parameter int CCW = 22,
  parameter int PW  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  cfg_t                  cfg_i,
  input  logic                  valid_i,
  input  logic signed [CCW-1:0] cam_i [3],
  output logic                  valid_o,
  output logic signed [PW-1:0]  pix_u,
  output logic signed [PW-1:0]  pix_v,
  output logic signed [CW+1:0]  depth_o,
  output logic                  sat_o
);

  localparam int DW   = CW + 2;
  localparam int QW   = ((PW > CENTER_W) ? PW : CENTER_W) + 1;
  localparam int NW   = CCW + FOCAL_W + 1;
  localparam int NNW  = NW + 2;
  localparam int DDW  = CCW + 1;
  localparam int RW   = DDW + QW + 1;
  localparam int CMPW = ((NNW > DDW + QW) ? NNW : DDW + QW) + 1;
  localparam int SW   = QW + 2;

  localparam logic signed [CCW-1:0] DMAX = {{(CCW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [CCW-1:0] DMIN = ~DMAX;
  localparam logic signed [SW-1:0]  PMAX = {{(SW-PW+1){1'b0}}, {(PW-1){1'b1}}};
  localparam logic signed [SW-1:0]  PMIN = ~PMAX;

  typedef struct packed {
    logic [1:0]           neg;
    logic [1:0]           ovf;
    logic [1:0]           pos;
    logic                 zero;
    logic signed [DW-1:0] depth;
  } side_t;

  // stage 1: focal products
  logic                 v1_r;
  logic signed [NW-1:0] num_r [2];
  logic signed [CCW-1:0] cz1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0] <= NW'($signed({1'b0, cfg_i.focal_u}) * cam_i[0]);
      num_r[1] <= NW'($signed({1'b0, cfg_i.focal_v}) * cam_i[1]);
      cz1_r    <= cam_i[2];
    end
  end

  // stage 2: magnitudes, rounded numerator, doubled denominator, depth clip
  logic              v2_r;
  logic [NNW-1:0]    nn_r [2];
  logic [DDW-1:0]    dd_r;
  side_t             s2_r;
  logic [NW-1:0]     an [2];
  logic [CCW-1:0]    ad;

  always_comb begin
    ad = cz1_r[CCW-1] ? CCW'(-cz1_r) : CCW'(cz1_r);
    for (int l = 0; l < 2; l++) begin
      an[l] = num_r[l][NW-1] ? NW'(-num_r[l]) : NW'(num_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        nn_r[l]       <= (NNW'(an[l]) << 1) + NNW'(ad);
        s2_r.neg[l]   <= num_r[l][NW-1] ^ cz1_r[CCW-1];
        s2_r.pos[l]   <= ~num_r[l][NW-1];
      end
      dd_r       <= DDW'(ad) << 1;
      s2_r.ovf   <= 2'b00;
      s2_r.zero  <= (cz1_r == '0);
      if (cz1_r > DMAX)      s2_r.depth <= DW'(DMAX);
      else if (cz1_r < DMIN) s2_r.depth <= DW'(DMIN);
      else                   s2_r.depth <= DW'(cz1_r);
    end
  end

  // stage 3: quotient overflow test, remainder start
  logic           dv_r  [QW+1];
  logic [RW-1:0]  rem_r [QW+1][2];
  logic [QW-1:0]  quo_r [QW+1][2];
  logic [DDW-1:0] den_r [QW+1];
  side_t          sd_r  [QW+1];
  side_t          s3;

  always_comb begin
    s3        = s2_r;
    s3.ovf[0] = CMPW'(nn_r[0]) >= (CMPW'(dd_r) << QW);
    s3.ovf[1] = CMPW'(nn_r[1]) >= (CMPW'(dd_r) << QW);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        rem_r[0][l] <= RW'(nn_r[l]);
        quo_r[0][l] <= '0;
      end
      den_r[0] <= dd_r;
      sd_r[0]  <= s3;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int K = QW - 1 - s;
    logic [RW-1:0] sub [2];
    logic          take [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        sub[l]  = RW'(den_r[s]) << K;
        take[l] = rem_r[s][l] >= sub[l];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          rem_r[s+1][l] <= take[l] ? rem_r[s][l] - sub[l] : rem_r[s][l];
          quo_r[s+1][l] <= quo_r[s][l] | (QW'(take[l]) << K);
        end
        den_r[s+1] <= den_r[s];
        sd_r[s+1]  <= sd_r[s];
      end
    end
  end

  // final stage: sign, center offset, clip
  logic signed [SW-1:0] sum [2];
  logic signed [PW-1:0] pix [2];
  logic [1:0]           hit;
  logic signed [SW-1:0] ctr [2];
  side_t                sf;

  assign sf     = sd_r[QW];
  assign ctr[0] = SW'(cfg_i.center_u);
  assign ctr[1] = SW'(cfg_i.center_v);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sum[l] = (sf.neg[l] ? -$signed(SW'(quo_r[QW][l])) : $signed(SW'(quo_r[QW][l])))
             + ctr[l];
      hit[l] = 1'b1;
      if (sf.zero) begin
        pix[l] = sf.pos[l] ? PW'(PMAX) : PW'(PMIN);
      end else if (sf.ovf[l]) begin
        pix[l] = sf.neg[l] ? PW'(PMIN) : PW'(PMAX);
      end else if (sum[l] > PMAX) begin
        pix[l] = PW'(PMAX);
      end else if (sum[l] < PMIN) begin
        pix[l] = PW'(PMIN);
      end else begin
        pix[l] = PW'(sum[l]);
        hit[l] = 1'b0;
      end
    end
  end

  logic                 vo_r;
  logic signed [PW-1:0] pu_r, pv_r;
  logic signed [DW-1:0] dep_r;
  logic                 sat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pu_r  <= pix[0];
      pv_r  <= pix[1];
      dep_r <= sf.depth;
      sat_r <= |hit;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
      for (int s = 0; s <= QW; s++) dv_r[s] <= 1'b0;
    end else if (en) begin
      v1_r    <= valid_i;
      v2_r    <= v1_r;
      dv_r[0] <= v2_r;
      for (int s = 0; s < QW; s++) dv_r[s+1] <= dv_r[s];
      vo_r    <= dv_r[QW];
    end
  end

  assign valid_o = vo_r;
  assign pix_u   = pu_r;
  assign pix_v   = pv_r;
  assign depth_o = dep_r;
  assign sat_o   = sat_r;

endmodule
